/* hdl/binary_to_seven_segment_display_core_macros.svh */
// Assertion macros for the binary to seven-segment display core checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef BINARY_TO_SEVEN_SEGMENT_DISPLAY_CORE_MACROS_SVH
`define BINARY_TO_SEVEN_SEGMENT_DISPLAY_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define B2S_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define B2S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/b2s_pkg.sv */
// Shared constants, types and the digit pattern table of the display core.
// No dependencies.
package b2s_pkg;

    localparam int VALUE_W       = 32;
    localparam int NUM_DIGITS    = 7;
    localparam int DIGIT_W       = 4;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
    localparam int BITS_PER_CELL = 4;
    localparam int NUM_CELLS     = VALUE_W / BITS_PER_CELL;
    localparam int OUT_POSITIONS = 7;
    localparam int SEG_W         = 7;
    localparam int ALWAYS_SHOWN  = 2;

    typedef logic [SEG_W-1:0] t_seg;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] rest;
    } t_cell_data;

    // Standard patterns, bit0 = A up to bit6 = G.
    function automatic t_seg seg_pattern(input logic [DIGIT_W-1:0] dig);
        t_seg pat;
        case (dig)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

/* hdl/b2s_if.sv */
// Request channel interfaces of the display core: binary value in, segments out.
// Depends on b2s_pkg.
interface b2s_in_if;
    logic                        valid;
    logic                        ready;
    logic [b2s_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2s_out_if;
    logic              valid;
    logic              ready;
    b2s_pkg::t_seg     digit0_segments;
    b2s_pkg::t_seg     digit1_segments;
    b2s_pkg::t_seg     digit2_segments;
    b2s_pkg::t_seg     digit3_segments;
    b2s_pkg::t_seg     digit4_segments;
    b2s_pkg::t_seg     digit5_segments;
    b2s_pkg::t_seg     digit6_segments;
    logic              dot_on;

    modport source (output valid, output digit0_segments, output digit1_segments,
                    output digit2_segments, output digit3_segments,
                    output digit4_segments, output digit5_segments,
                    output digit6_segments, output dot_on, input ready);
    modport sink   (input valid, input digit0_segments, input digit1_segments,
                    input digit2_segments, input digit3_segments,
                    input digit4_segments, input digit5_segments,
                    input digit6_segments, input dot_on, output ready);
endinterface

/* hdl/b2s_cell.sv */
// One conversion cell: shifts four binary bits into the BCD accumulator.
// Depends on b2s_pkg.
module b2s_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b2s_pkg::t_cell_data i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output b2s_pkg::t_cell_data o_data
);
    import b2s_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    // Load when empty or when the next cell takes the current request.
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] dig;
        bcd  = i_data.bcd;
        rest = i_data.rest;
        dig  = '0;
        for (int s = 0; s < BITS_PER_CELL; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                dig = bcd[d*DIGIT_W +: DIGIT_W];
                if (dig inside {[4'd5:4'd15]}) begin
                    bcd[d*DIGIT_W +: DIGIT_W] = dig + 4'd3;
                end
            end
            // Carry out of the top digit drops: keeps the value modulo 10^n.
            bcd  = {bcd[BCD_W-2:0], rest[VALUE_W-1]};
            rest = {rest[VALUE_W-2:0], 1'b0};
        end
        n_data.bcd  = bcd;
        n_data.rest = rest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hdl/b2s_seg_decode.sv */
// Segment decoder with leading-zero blanking for the finished BCD digits.
// Depends on b2s_pkg.
module b2s_seg_decode (
    input  logic [b2s_pkg::BCD_W-1:0]                         i_bcd,
    output b2s_pkg::t_seg [b2s_pkg::OUT_POSITIONS-1:0]        o_seg
);
    import b2s_pkg::*;

    always_comb begin
        logic               lit;
        logic [DIGIT_W-1:0] dig;
        lit   = 1'b0;
        dig   = '0;
        o_seg = '0;
        // Scan from the top: show a position once a nonzero digit is seen; the two lowest always show.
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            dig = i_bcd[i*DIGIT_W +: DIGIT_W];
            if (dig != '0 || i < ALWAYS_SHOWN) begin
                lit = 1'b1;
            end
            if (i < OUT_POSITIONS && lit) begin
                o_seg[i] = seg_pattern(dig);
            end
        end
    end

endmodule

/* hdl/binary_to_seven_segment_display_core.sv */
// Binary to seven-segment display core, top level.
// Depends on b2s_pkg, b2s_if, b2s_cell and b2s_seg_decode.
//
// Usage:
//   i_in  carries one 32-bit unsigned value per request (valid/ready).
//   o_out carries seven segment patterns (bit0 = A .. bit6 = G) and the dot,
//         which is always lit. The low seven decimal digits are shown; zeros
//         above the highest nonzero digit are blanked in the five upper
//         positions, the two lowest positions always show their digit.
//   Each accepted value passes through the chain of eight registered conversion
//   cells before o_out.valid; each cell shifts 4 input bits through a double-dabble step.
//   Throughput: one request per cycle while o_out.ready is high, set by the
//   chain of eight cells that each hold one request in flight.
//   Reset clears the valid bit of every cell; the pipeline starts empty.
//   Stall: a cell holds its request while the next one is full and stalled;
//   empty cells upstream still take new requests, so i_in.ready stays high
//   until the whole chain is full.
module binary_to_seven_segment_display_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b2s_in_if.sink    i_in,
    b2s_out_if.source o_out
);
    import b2s_pkg::*;

    logic       c_valid [NUM_CELLS+1];
    logic       c_ready [NUM_CELLS+1];
    t_cell_data c_data  [NUM_CELLS+1];
    t_seg [OUT_POSITIONS-1:0] seg;

    // Seed the chain: empty accumulator, all value bits still to shift.
    assign c_valid[0]     = i_in.valid;
    assign c_data[0].bcd  = '0;
    assign c_data[0].rest = i_in.value;
    assign i_in.ready     = c_ready[0];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        b2s_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    assign c_ready[NUM_CELLS] = o_out.ready;

    // Decode the last cell's digits straight onto the output channel.
    b2s_seg_decode u_decode (
        .i_bcd (c_data[NUM_CELLS].bcd),
        .o_seg (seg)
    );

    assign o_out.valid           = c_valid[NUM_CELLS];
    assign o_out.digit0_segments = seg[0];
    assign o_out.digit1_segments = seg[1];
    assign o_out.digit2_segments = seg[2];
    assign o_out.digit3_segments = seg[3];
    assign o_out.digit4_segments = seg[4];
    assign o_out.digit5_segments = seg[5];
    assign o_out.digit6_segments = seg[6];
    assign o_out.dot_on          = 1'b1;

endmodule

/* hdl/b2s_checker.sv */
// Port-level checker for the display core, bound to the top level.
// Depends on b2s_pkg and binary_to_seven_segment_display_core_macros.svh.
`include "binary_to_seven_segment_display_core_macros.svh"

module b2s_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input b2s_pkg::t_seg i_seg2,
    input b2s_pkg::t_seg i_seg3,
    input b2s_pkg::t_seg i_seg4,
    input b2s_pkg::t_seg i_seg5,
    input b2s_pkg::t_seg i_seg6,
    input b2s_pkg::t_seg i_seg0,
    input b2s_pkg::t_seg i_seg1,
    input logic          i_dot_on
);
    import b2s_pkg::*;

    `B2S_ASSERT_ALWAYS(a_dot_lit, !i_out_valid || i_dot_on, "decimal dot not lit")

    `B2S_ASSERT_ALWAYS(a_low_shown, !i_out_valid || (i_seg0 != '0 && i_seg1 != '0),
        "lowest two positions blanked")

    `B2S_ASSERT_ALWAYS(a_blank_order,
        !i_out_valid || i_seg6 == '0 || (i_seg5 != '0 && i_seg4 != '0 &&
        i_seg3 != '0 && i_seg2 != '0), "zero below a shown digit blanked")

    `B2S_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid,
        "result dropped while stalled")

endmodule

bind binary_to_seven_segment_display_core b2s_checker u_b2s_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_seg2      (o_out.digit2_segments),
    .i_seg3      (o_out.digit3_segments),
    .i_seg4      (o_out.digit4_segments),
    .i_seg5      (o_out.digit5_segments),
    .i_seg6      (o_out.digit6_segments),
    .i_seg0      (o_out.digit0_segments),
    .i_seg1      (o_out.digit1_segments),
    .i_dot_on    (o_out.dot_on)
);
